/* rtl/core/mnpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnpp_pkg
// Shared types and constants of the midi note packet parser core.
// ----------------------------------------------------------------------------

package mnpp_pkg;

    localparam logic [7:0] STATUS_LOW      = 8'd128;
    localparam logic [7:0] STATUS_HIGH     = 8'd159;
    localparam logic [7:0] STATUS_OFF_HIGH = 8'd143;
    localparam logic [7:0] PITCH_LOW       = 8'd21;
    localparam logic [7:0] PITCH_HIGH      = 8'd108;
    localparam logic [7:0] VEL_HIGH        = 8'd127;
    localparam logic [9:0] RESET_LEN_A     = 10'd152;
    localparam logic [9:0] RESET_LEN_B     = 10'd154;
    localparam logic [8:0] COUNT_MAX       = 9'd511;
    localparam logic [6:0] MIN_VEL_RESET   = 7'd1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PITCH = 2'd1,
        MODE_VEL   = 2'd2
    } parse_mode_t;

    typedef enum logic {
        KIND_NOTE      = 1'b0,
        KIND_RESET_ALL = 1'b1
    } event_kind_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [6:0]  note_index;
        logic [6:0]  velocity;
        logic        last_event;
    } note_event_t;

endpackage

/* rtl/core/midi_note_packet_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_packet_parser_core
// Parses wireless midi packets byte by byte into note and reset-all events.
// ----------------------------------------------------------------------------
// Takes one packet byte per beat on the s_ side (s_tlast on the final byte of
// the packet; the first byte is a header and is skipped) and returns note
// events on the m_ side. A byte is taken into an input register and parsed
// from there once the queue has room for two events; its zero, one or two
// events are written into a four entry result queue, whose head drives the
// m_ side with m_tvalid high while the queue is not empty. The parser takes
// one byte per cycle while the queue holds at most two events; the queue
// drains one event per cycle while m_tready is high, so the sustained rate
// is one byte per cycle when each byte gives at most one event and m_tready
// stays high, and one event per cycle of m_tready otherwise. min_velocity
// is loaded through cfg_wr_en / cfg_wr_data and resets to 1.

module midi_note_packet_parser_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // min_velocity

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [6:0] note_index, [13:7] velocity, [15:14] zero
    output logic        m_tuser,       // event_kind
    output logic        m_tlast        // last_event
);

    // configuration
    logic [6:0] min_vel_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    mnpp_pkg::parse_mode_t mode_reg, mode_next;
    logic       off_reg, off_next;
    logic [6:0] pitch_reg, pitch_next;
    logic [8:0] count_reg, count_next;

    // result queue
    mnpp_pkg::note_event_t          queue_reg [mnpp_pkg::QUEUE_DEPTH];
    logic [mnpp_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [mnpp_pkg::QCNT_W-1:0]    fill_reg;

    localparam logic [mnpp_pkg::QPTR_W-1:0] QPTR_ONE = mnpp_pkg::QPTR_W'(1);

    logic       consume;
    logic       pop;
    logic       note_hit;
    logic       reset_hit;
    logic [6:0] note_vel;
    logic [6:0] note_idx;
    logic [9:0] pkt_len;
    logic [1:0] push_cnt;
    mnpp_pkg::note_event_t ev0, ev1;
    logic       is_status;

    // room for two events keeps the ready path free of m_tready
    assign consume  = in_valid_reg && (fill_reg <= mnpp_pkg::QCNT_W'(mnpp_pkg::QUEUE_DEPTH - 2));
    assign s_tready = !in_valid_reg || consume;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_vel_reg <= mnpp_pkg::MIN_VEL_RESET;
        end else if (cfg_wr_en) begin
            min_vel_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // parse step for the byte in the input register
    always_comb begin
        mode_next  = mode_reg;
        off_next   = off_reg;
        pitch_next = pitch_reg;
        count_next = count_reg;
        note_hit   = 1'b0;
        note_vel   = 7'd0;
        note_idx   = pitch_reg - 7'(mnpp_pkg::PITCH_LOW);
        is_status  = (in_byte_reg >= mnpp_pkg::STATUS_LOW) &&
                     (in_byte_reg <= mnpp_pkg::STATUS_HIGH);

        if (count_reg != 9'd0) begin
            unique case (mode_reg)
                mnpp_pkg::MODE_PITCH: begin
                    if (in_byte_reg >= mnpp_pkg::PITCH_LOW &&
                        in_byte_reg <= mnpp_pkg::PITCH_HIGH) begin
                        pitch_next = in_byte_reg[6:0];
                        mode_next  = mnpp_pkg::MODE_VEL;
                    end else begin
                        mode_next = is_status ? mnpp_pkg::MODE_PITCH : mnpp_pkg::MODE_IDLE;
                        if (is_status) begin
                            off_next = (in_byte_reg <= mnpp_pkg::STATUS_OFF_HIGH);
                        end
                    end
                end
                mnpp_pkg::MODE_VEL: begin
                    if (in_byte_reg <= mnpp_pkg::VEL_HIGH) begin
                        if (off_reg || in_byte_reg == 8'd0) begin
                            note_hit = 1'b1;
                        end else if (in_byte_reg[6:0] >= min_vel_reg) begin
                            note_hit = 1'b1;
                            note_vel = in_byte_reg[6:0];
                        end
                        mode_next = mnpp_pkg::MODE_PITCH;
                    end else begin
                        mode_next = is_status ? mnpp_pkg::MODE_PITCH : mnpp_pkg::MODE_IDLE;
                        if (is_status) begin
                            off_next = (in_byte_reg <= mnpp_pkg::STATUS_OFF_HIGH);
                        end
                    end
                end
                default: begin
                    // idle, and the unused code behaves as idle
                    mode_next = is_status ? mnpp_pkg::MODE_PITCH : mnpp_pkg::MODE_IDLE;
                    if (is_status) begin
                        off_next = (in_byte_reg <= mnpp_pkg::STATUS_OFF_HIGH);
                    end
                end
            endcase
        end

        pkt_len   = {1'b0, count_reg} + 10'd1;
        reset_hit = in_last_reg &&
                    (pkt_len == mnpp_pkg::RESET_LEN_A || pkt_len == mnpp_pkg::RESET_LEN_B);

        if (in_last_reg) begin
            mode_next  = mnpp_pkg::MODE_IDLE;
            count_next = 9'd0;
        end else if (count_reg != mnpp_pkg::COUNT_MAX) begin
            count_next = count_reg + 9'd1;
        end

        // event of the pair first, reset-all after it
        ev0.event_kind = note_hit ? mnpp_pkg::KIND_NOTE : mnpp_pkg::KIND_RESET_ALL;
        ev0.note_index = note_hit ? note_idx : 7'd0;
        ev0.velocity   = note_vel;
        ev0.last_event = !(note_hit && reset_hit);

        ev1.event_kind = mnpp_pkg::KIND_RESET_ALL;
        ev1.note_index = 7'd0;
        ev1.velocity   = 7'd0;
        ev1.last_event = 1'b1;

        push_cnt = consume ? (2'(note_hit) + 2'(reset_hit)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= mnpp_pkg::MODE_IDLE;
            off_reg   <= 1'b0;
            pitch_reg <= 7'd0;
            count_reg <= 9'd0;
        end else if (consume) begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            pitch_reg <= pitch_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= ev0;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_ONE] <= ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + mnpp_pkg::QPTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_ONE;
            end
            fill_reg <= fill_reg + mnpp_pkg::QCNT_W'(push_cnt) - mnpp_pkg::QCNT_W'(pop);
        end
    end

    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {2'b00, queue_reg[rd_ptr_reg].velocity, queue_reg[rd_ptr_reg].note_index};
    assign m_tuser  = queue_reg[rd_ptr_reg].event_kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last_event;

endmodule

/* dv/midi_note_packet_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_packet_parser_core_tb
// Self-checking bench for the midi note packet parser core.
// ----------------------------------------------------------------------------
// Packets go in one byte per beat on the s_ side. A behavioral parser in this
// bench tracks running status, the held pitch and the byte count, and queues
// the note and reset-all events that each byte must give. Every m_ beat is
// checked against the oldest queued event. Directed packets cover the edges of
// the status, pitch and velocity ranges, broken pairs, reset lengths and the
// count limit; random packets follow under several min_velocity settings, with
// random gaps on the sender and stalls on the receiver in all but the last run.

module midi_note_packet_parser_core_tb;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // behavioral parser state
    mnpp_pkg::parse_mode_t prs_mode;
    logic        prs_off;
    logic [6:0]  prs_pitch;
    logic [8:0]  prs_count;
    logic [6:0]  prs_min_vel;

    mnpp_pkg::note_event_t expected_events[$];
    logic [7:0]  pkt_buf[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    bit          idle_on    = 1'b1;

    midi_note_packet_parser_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // event prediction
    // ------------------------------------------------------------------------

    task automatic take_status(input logic [7:0] b);
        if (b >= mnpp_pkg::STATUS_LOW && b <= mnpp_pkg::STATUS_HIGH) begin
            prs_mode = mnpp_pkg::MODE_PITCH;
            prs_off  = (b <= mnpp_pkg::STATUS_OFF_HIGH);
        end else begin
            prs_mode = mnpp_pkg::MODE_IDLE;
        end
    endtask

    task automatic predict_events(input logic [7:0] b, input logic last);
        mnpp_pkg::note_event_t evs[2];
        int          n;
        logic [9:0]  pkt_len;
        n = 0;
        pkt_len = {1'b0, prs_count} + 10'd1;
        if (prs_count != 9'd0) begin
            case (prs_mode)
                mnpp_pkg::MODE_PITCH: begin
                    if (b >= mnpp_pkg::PITCH_LOW && b <= mnpp_pkg::PITCH_HIGH) begin
                        prs_pitch = b[6:0];
                        prs_mode  = mnpp_pkg::MODE_VEL;
                    end else begin
                        take_status(b);
                    end
                end
                mnpp_pkg::MODE_VEL: begin
                    if (b <= mnpp_pkg::VEL_HIGH) begin
                        if (prs_off || b == 8'd0 || b[6:0] >= prs_min_vel) begin
                            evs[n].event_kind = mnpp_pkg::KIND_NOTE;
                            evs[n].note_index = 7'(prs_pitch - mnpp_pkg::PITCH_LOW);
                            evs[n].velocity   = (prs_off || b == 8'd0) ? 7'd0 : b[6:0];
                            evs[n].last_event = 1'b0;
                            n++;
                        end
                        prs_mode = mnpp_pkg::MODE_PITCH;
                    end else begin
                        take_status(b);
                    end
                end
                default: take_status(b);
            endcase
        end
        if (last) begin
            if (pkt_len == mnpp_pkg::RESET_LEN_A || pkt_len == mnpp_pkg::RESET_LEN_B) begin
                evs[n].event_kind = mnpp_pkg::KIND_RESET_ALL;
                evs[n].note_index = 7'd0;
                evs[n].velocity   = 7'd0;
                evs[n].last_event = 1'b0;
                n++;
            end
            prs_mode  = mnpp_pkg::MODE_IDLE;
            prs_count = 9'd0;
        end else if (prs_count < mnpp_pkg::COUNT_MAX) begin
            prs_count++;
        end
        if (n > 0) evs[n - 1].last_event = 1'b1;
        for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls and checking
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        mnpp_pkg::note_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: beat with nothing expected, actual kind %0d note %0d vel %0d last %0d",
                         $time, m_tuser, m_tdata[6:0], m_tdata[13:7], m_tlast);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, m_tuser);
                check_field("note_index", want.note_index, m_tdata[6:0]);
                check_field("velocity", want.velocity, m_tdata[13:7]);
                check_field("last_event", want.last_event, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_events(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++) begin
            send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
        end
        pkt_buf.delete();
    endtask

    // sender holds off until every queued event has come out
    task automatic wait_events_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    // a byte with no event may still be in flight, so keep waiting after the drain
    task automatic settle();
        wait_events_done();
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_min_velocity(input logic [6:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        prs_min_vel = v;
        @(posedge aclk);
    endtask

    // header, a status byte and back-to-back valid pairs with nonzero velocity
    task automatic build_note_run(input int len, input logic [7:0] status);
        pkt_buf.push_back(8'($urandom_range(0, 255)));
        pkt_buf.push_back(status);
        while (pkt_buf.size() < len) begin
            pkt_buf.push_back(8'($urandom_range(mnpp_pkg::PITCH_LOW, mnpp_pkg::PITCH_HIGH)));
            pkt_buf.push_back(8'($urandom_range(1, 127)));
        end
        while (pkt_buf.size() > len) void'(pkt_buf.pop_back());
    endtask

    task automatic build_random_packet(input int len);
        int r;
        pkt_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) pkt_buf.push_back(8'($urandom_range(128, 159)));
        while (pkt_buf.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                pkt_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 18) begin
                pkt_buf.push_back(8'($urandom_range(128, 159)));
            end else begin
                r = $urandom_range(0, 9);
                pkt_buf.push_back(r == 0 ? mnpp_pkg::PITCH_LOW :
                                  r == 1 ? mnpp_pkg::PITCH_HIGH :
                                  8'($urandom_range(mnpp_pkg::PITCH_LOW,
                                                    mnpp_pkg::PITCH_HIGH)));
                r = $urandom_range(0, 9);
                pkt_buf.push_back(r == 0 ? 8'd0 : r == 1 ? mnpp_pkg::VEL_HIGH :
                                  r == 2 ? {1'b0, prs_min_vel} :
                                  r == 3 ? {1'b0, prs_min_vel} - 8'd1 :
                                  8'($urandom_range(0, 127)));
            end
        end
        while (pkt_buf.size() > len) void'(pkt_buf.pop_back());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_header_only();
        pkt_buf = '{8'd0};
        send_packet();
        pkt_buf = '{8'd255};
        send_packet();
    endtask

    task automatic test_status_range();
        // 127 is no status, 128 and 143 are note-off runs, 144 and 159 note-on, 160 none
        pkt_buf = '{8'd0, 8'd127, 8'd60, 8'd64, 8'd128, 8'd21, 8'd60, 8'd143, 8'd108, 8'd90};
        send_packet();
        pkt_buf = '{8'd7, 8'd144, 8'd108, 8'd127, 8'd159, 8'd60, 8'd1, 8'd160, 8'd60, 8'd60};
        send_packet();
    endtask

    task automatic test_pair_limits();
        // out of range pitch or velocity ends the run and is retried as status
        pkt_buf = '{8'd0, 8'd144, 8'd20, 8'd60, 8'd144, 8'd109, 8'd144, 8'd21, 8'd0,
                    8'd21, 8'd128, 8'd60, 8'd100, 8'd150, 8'd70, 8'd90, 8'd255, 8'd60, 8'd9};
        send_packet();
    endtask

    task automatic test_incomplete_pair();
        pkt_buf = '{8'd0, 8'd144, 8'd60};
        send_packet();
        pkt_buf = '{8'd144, 8'd144, 8'd60, 8'd100, 8'd70};
        send_packet();
    endtask

    task automatic test_min_velocity();
        set_min_velocity(7'd127);
        pkt_buf = '{8'd0, 8'd144, 8'd60, 8'd126, 8'd61, 8'd127, 8'd62, 8'd0};
        send_packet();
        set_min_velocity(7'd0);
        pkt_buf = '{8'd0, 8'd159, 8'd60, 8'd1, 8'd61, 8'd0};
        send_packet();
        set_min_velocity(7'd64);
        pkt_buf = '{8'd0, 8'd150, 8'd60, 8'd63, 8'd61, 8'd64, 8'd142, 8'd62, 8'd3};
        send_packet();
    endtask

    task automatic test_reset_lengths();
        set_min_velocity(7'd1);
        // note-on pair on the last byte, then reset-all
        build_note_run(154, 8'($urandom_range(144, 159)));
        send_packet();
        // lone pitch on the last byte and no reset length
        build_note_run(153, 8'($urandom_range(128, 159)));
        send_packet();
        // reset-all alone when the last byte gives no note
        build_note_run(151, 8'd130);
        pkt_buf.push_back(8'd200);
        send_packet();
    endtask

    task automatic test_count_limit();
        build_random_packet(513);
        send_packet();
    endtask

    task automatic test_random_packets(input int n_bytes, input logic [6:0] min_vel);
        int stop_at;
        int r;
        set_min_velocity(min_vel);
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 10) build_random_packet($urandom_range(1, 3));
            else        build_random_packet($urandom_range(4, 30));
            if ($urandom_range(0, 9) == 0) begin
                // split the packet with a full drain of the result side
                r = $urandom_range(0, pkt_buf.size() - 1);
                for (int i = 0; i < pkt_buf.size(); i++) begin
                    if (i == r) wait_events_done();
                    send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
                end
                pkt_buf.delete();
            end else begin
                send_packet();
            end
        end
    endtask

    initial begin
        prs_mode    = mnpp_pkg::MODE_IDLE;
        prs_off     = 1'b0;
        prs_pitch   = 7'd0;
        prs_count   = 9'd0;
        prs_min_vel = mnpp_pkg::MIN_VEL_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_only();
        test_status_range();
        test_pair_limits();
        test_incomplete_pair();
        test_min_velocity();
        test_reset_lengths();
        test_count_limit();
        test_random_packets(40, 7'd0);
        test_random_packets(40, 7'd127);
        test_random_packets(40, 7'd1);
        test_random_packets(40, 7'($urandom_range(2, 126)));
        idle_on = 1'b0;
        test_random_packets(40, 7'($urandom_range(0, 127)));

        settle();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
